// ----- design/smmrm_pkg.sv -----
// Shared constants of the min/max/RMS level meter.
package smmrm_pkg;

  localparam int LIMIT_BITS       = 25;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int DEF_COUNT_BITS   = 24;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

endpackage

// ----- design/signal_min_max_rms_meter.sv -----
// Level meter: sample count, minimum, maximum and RMS of signed fixed-point audio.
//
// Each input item is either a sample to collect or a clear, and each item returns
// one result: the count, minimum, maximum, done flag and RMS after that item.
// Accumulating a sample runs the bit-serial datapath: a shift-add squarer, a
// restoring divider that produces one quotient bit per cycle and a restoring
// square root that settles one root bit per cycle. A clear empties the statistics,
// and a sample that arrives once the frame limit is reached reuses the stored RMS;
// both go straight to the output stage. Only one item is in flight at a time, but
// a finished result sits in the output register, so a new item may be accepted
// while it waits.
module signal_min_max_rms_meter
  import smmrm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write,
  input  logic [LIMIT_BITS-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COUNT_BITS:0]           out_count,
  output logic signed [SAMPLE_BITS-1:0] out_minimum,
  output logic signed [SAMPLE_BITS-1:0] out_maximum,
  output logic [SAMPLE_BITS-1:0]        out_rms_level,
  output logic                          out_done_res
);

  localparam int CNT_W     = COUNT_BITS + 1;
  localparam int QUO_BITS  = 2 * SAMPLE_BITS - 1;
  localparam int SUM_BITS  = QUO_BITS + COUNT_BITS;
  localparam int RAD_BITS  = 2 * SAMPLE_BITS;
  localparam int STEP_BITS = $clog2(RAD_BITS);
  localparam int CMP_BITS  = LIMIT_BITS > CNT_W ? LIMIT_BITS : CNT_W;

  localparam logic [CMP_BITS-1:0] COUNT_CAP = CMP_BITS'(1) << COUNT_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [STEP_BITS-1:0]          step_r;
  logic [LIMIT_BITS-1:0]         frame_limit_r;

  logic [CNT_W-1:0]              count_r;
  logic [SUM_BITS-1:0]           sum_r;
  logic signed [SAMPLE_BITS-1:0] least_r, greatest_r;
  logic [SAMPLE_BITS-1:0]        rms_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  logic [SAMPLE_BITS:0]          mul_hi_r;
  logic [SAMPLE_BITS-1:0]        mul_lo_r, mcand_r;
  logic [CNT_W-1:0]              div_rem_r;
  logic [QUO_BITS-1:0]           div_quo_r;
  logic [RAD_BITS-1:0]           rad_r;
  logic [SAMPLE_BITS+1:0]        sq_rem_r;
  logic [SAMPLE_BITS-1:0]        root_r;

  logic                          out_valid_r, out_done_r;
  logic [CNT_W-1:0]              out_count_r;
  logic signed [SAMPLE_BITS-1:0] out_min_r, out_max_r;
  logic [SAMPLE_BITS-1:0]        out_rms_r;

  logic in_fire, emit_fire, below_limit, mul_last, div_last, sqrt_last;
  logic [CMP_BITS-1:0]     lim_ext, lim_eff;
  logic [SAMPLE_BITS-1:0]  in_mag;
  logic [SAMPLE_BITS:0]    mul_s;
  logic [RAD_BITS-1:0]     product;
  logic [SUM_BITS-1:0]     sum_nxt;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W:0]          div_trial, div_sub;
  logic                    div_ge;
  logic [CNT_W-1:0]        div_rem_nxt;
  logic [QUO_BITS-1:0]     div_quo_nxt;
  logic [SAMPLE_BITS+3:0]  sq_t, sq_trial, sq_diff;
  logic                    sq_ge;
  logic [SAMPLE_BITS+1:0]  sq_rem_nxt;
  logic [SAMPLE_BITS-1:0]  root_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // A limit above the counter's capacity acts as the capacity itself.
  assign lim_ext     = CMP_BITS'(frame_limit_r);
  assign lim_eff     = (lim_ext > COUNT_CAP) ? COUNT_CAP : lim_ext;
  assign below_limit = CMP_BITS'(count_r) < lim_eff;

  assign in_mag = in_sample[SAMPLE_BITS-1] ? $unsigned(-in_sample) : $unsigned(in_sample);

  assign mul_last  = (step_r == STEP_BITS'(SAMPLE_BITS - 1));
  assign div_last  = (step_r == STEP_BITS'(QUO_BITS - 1));
  assign sqrt_last = mul_last;

  // Shift-add squarer: one multiplier bit per cycle, product grows from the top.
  assign mul_s   = mul_hi_r + (mul_lo_r[0] ? {1'b0, mcand_r} : '0);
  assign product = {mul_hi_r[SAMPLE_BITS-1:0], mul_lo_r};
  assign sum_nxt   = sum_r + SUM_BITS'(product);
  assign count_nxt = count_r + 1'b1;

  // Restoring divider. The quotient never exceeds one full-scale square, so only
  // its low QUO_BITS bits are developed and the upper dividend bits seed the remainder.
  assign div_trial   = {div_rem_r, div_quo_r[QUO_BITS-1]};
  assign div_sub     = div_trial - {1'b0, count_r};
  assign div_ge      = (div_trial >= {1'b0, count_r});
  assign div_rem_nxt = div_ge ? div_sub[CNT_W-1:0] : div_trial[CNT_W-1:0];
  assign div_quo_nxt = {div_quo_r[QUO_BITS-2:0], div_ge};

  // Restoring square root, two radicand bits in and one root bit out per cycle.
  assign sq_t       = {sq_rem_r, rad_r[RAD_BITS-1 -: 2]};
  assign sq_trial   = {2'b00, root_r, 2'b01};
  assign sq_diff    = sq_t - sq_trial;
  assign sq_ge      = (sq_t >= sq_trial);
  assign sq_rem_nxt = sq_ge ? sq_diff[SAMPLE_BITS+1:0] : sq_t[SAMPLE_BITS+1:0];
  assign root_nxt   = {root_r[SAMPLE_BITS-2:0], sq_ge};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_SAMPLE && below_limit) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        if (mul_last) state_nxt = ST_ACC;
      end
      ST_ACC:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      frame_limit_r <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      least_r       <= SAMPLE_TOP;
      greatest_r    <= SAMPLE_BOTTOM;
      rms_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write) frame_limit_r <= cfg_data;
      if (emit_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (in_fire) begin
            sample_r <= in_sample;
            mul_hi_r <= '0;
            mul_lo_r <= in_mag;
            mcand_r  <= in_mag;
            if (in_operation == OP_CLEAR) begin
              count_r    <= '0;
              sum_r      <= '0;
              least_r    <= SAMPLE_TOP;
              greatest_r <= SAMPLE_BOTTOM;
              rms_r      <= '0;
            end
          end
        end
        ST_MUL: begin
          mul_hi_r <= {1'b0, mul_s[SAMPLE_BITS:1]};
          mul_lo_r <= {mul_s[0], mul_lo_r[SAMPLE_BITS-1:1]};
          step_r   <= mul_last ? '0 : step_r + 1'b1;
        end
        ST_ACC: begin
          sum_r   <= sum_nxt;
          count_r <= count_nxt;
          if (sample_r < least_r) least_r <= sample_r;
          if (sample_r > greatest_r) greatest_r <= sample_r;
          div_rem_r <= CNT_W'(sum_nxt[SUM_BITS-1:QUO_BITS]);
          div_quo_r <= sum_nxt[QUO_BITS-1:0];
          step_r    <= '0;
        end
        ST_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          step_r    <= div_last ? '0 : step_r + 1'b1;
          if (div_last) begin
            rad_r    <= {1'b0, div_quo_nxt};
            sq_rem_r <= '0;
            root_r   <= '0;
          end
        end
        ST_SQRT: begin
          rad_r    <= {rad_r[RAD_BITS-3:0], 2'b00};
          sq_rem_r <= sq_rem_nxt;
          root_r   <= root_nxt;
          step_r   <= sqrt_last ? '0 : step_r + 1'b1;
          if (sqrt_last) rms_r <= root_nxt;
        end
        default: step_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_count_r <= count_r;
      out_min_r   <= least_r;
      out_max_r   <= greatest_r;
      out_rms_r   <= rms_r;
      out_done_r  <= !below_limit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_count     = out_count_r;
  assign out_minimum   = out_min_r;
  assign out_maximum   = out_max_r;
  assign out_rms_level = out_rms_r;
  assign out_done_res  = out_done_r;

  // An accepted item always starts work, so the input side closes on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("input accepted but block stayed idle");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (CMP_BITS'(out_count_r) <= COUNT_CAP))
    else $error("sample count exceeds capacity");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r != '0) |-> (out_min_r <= out_max_r))
    else $error("minimum above maximum with samples collected");

  a_empty_rms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r == '0) |-> (out_rms_r == '0 && out_min_r == SAMPLE_TOP))
    else $error("empty statistics not reported as empty");

endmodule
